// File: rtl/core/pairwise_repulsion_2x2_unit_macros.svh
// Assertion macros shared by the pairwise repulsion RTL.
`ifndef PAIRWISE_REPULSION_2X2_UNIT_MACROS_SVH
`define PAIRWISE_REPULSION_2X2_UNIT_MACROS_SVH

// Both macros expect signals named clk and rst in the enclosing module.
`define PR2_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define PR2_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/pr2x2_pkg.sv
// Types and constants for the pairwise repulsion unit.
package pr2x2_pkg;

  localparam int MAG_W  = 32;  // |difference| of two Q16.16 positions
  localparam int DEN_W  = 65;  // squared distance, also remainder width
  localparam int QB     = 48;  // quotient bits
  localparam int CHG_W  = 16;
  localparam int PROD_W = 64;
  localparam int TERM_W = 57;
  localparam int SUM_W  = 58;
  localparam int LANES  = 8;   // four pairs, two axes each
  localparam int PAIRS  = 4;
  localparam int TERMS  = 16;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
    logic signed [15:0] charge_a;
    logic signed [15:0] charge_b;
    logic signed [15:0] charge_c;
    logic signed [15:0] charge_d;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_a_x;
    logic signed [31:0] force_a_y;
    logic signed [31:0] force_b_x;
    logic signed [31:0] force_b_y;
    logic signed [31:0] force_c_x;
    logic signed [31:0] force_c_y;
    logic signed [31:0] force_d_x;
    logic signed [31:0] force_d_y;
    logic               zero_distance;
  } out_t;

  typedef struct packed {
    logic [LANES-1:0]            neg;
    logic [PAIRS-1:0][CHG_W-1:0] chg;
    logic [PAIRS-1:0]            zero;
  } side_t;

endpackage

// File: rtl/core/pairwise_repulsion_2x2_unit.sv
// Pairwise repulsion between vertex pairs (A,B) and (C,D), fully pipelined.
//
// Requests arrive on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data, one result per request, in order.
// The strength register is written with cfg_we/cfg_wdata only while idle,
// a rule for the user that the block does not enforce. The stages are
// difference, multiply, a stage summing the squares to load the divider,
// a restoring divider with one quotient bit per stage over 48 stages, a
// charge multiply, a rounding stage and the output register. A new request
// is taken in every cycle unless out_ready stalls the pipeline.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops until the result is taken.
// Synchronous reset empties the pipeline and sets strength to 1.0.
// A pair at zero distance adds nothing and sets zero_distance.
// Forces are saturated to the signed 32-bit range.
`include "pairwise_repulsion_2x2_unit_macros.svh"

module pairwise_repulsion_2x2_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  pr2x2_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pr2x2_pkg::out_t  out_data
);
  import pr2x2_pkg::*;

  logic        en;
  logic [31:0] strength;

  // stage 1
  logic signed [31:0]    px [PAIRS];
  logic signed [31:0]    py [PAIRS];
  logic signed [MAG_W:0] dd [LANES];
  logic [MAG_W-1:0]      m1 [LANES];
  logic [LANES-1:0]      n1;
  logic [PAIRS-1:0][CHG_W-1:0] c1;
  logic                  v1;

  // stage 2
  logic [PROD_W-1:0]     sq2 [LANES];
  logic [PROD_W-1:0]     pr2 [LANES];
  logic [LANES-1:0]      n2;
  logic [PAIRS-1:0][CHG_W-1:0] c2;
  logic                  v2;

  // divider, index 0 is the loaded stage
  logic [DEN_W-1:0]            drem  [0:QB][LANES];
  logic [QB-1:0]               dsh   [0:QB][LANES];
  logic [PAIRS-1:0][DEN_W-1:0] dden  [0:QB];
  side_t                       dside [0:QB];
  logic [QB:0]                 dv;

  // weighting
  logic [PROD_W-1:0]        pm  [TERMS];
  logic [TERMS-1:0]         ngw;
  logic                     vw1;
  logic signed [TERM_W-1:0] tv  [TERMS];
  logic                     vw2;
  logic                     zw1;
  logic                     zw2;

  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [31:0] r;
    if (!v[SUM_W-1] && (|v[SUM_W-2:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= 32'd65536;
    end else if (cfg_we) begin
      strength <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      dv        <= '0;
      vw1       <= 1'b0;
      vw2       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      dv        <= {dv[QB-1:0], v2};
      vw1       <= dv[QB];
      vw2       <= vw1;
      out_valid <= vw2;
    end
  end

  // Pair k runs from self (A or B) to partner (C or D); lane 2k is x, 2k+1 is y.
  always_comb begin
    px[0] = in_data.a_x;  py[0] = in_data.a_y;
    px[1] = in_data.b_x;  py[1] = in_data.b_y;
    px[2] = in_data.c_x;  py[2] = in_data.c_y;
    px[3] = in_data.d_x;  py[3] = in_data.d_y;
    for (int k = 0; k < PAIRS; k++) begin
      dd[2*k]   = (MAG_W+1)'(px[2 + (k >> 1)]) - (MAG_W+1)'(px[k & 1]);
      dd[2*k+1] = (MAG_W+1)'(py[2 + (k >> 1)]) - (MAG_W+1)'(py[k & 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < LANES; j++) begin
        n1[j] <= dd[j][MAG_W];
        m1[j] <= dd[j][MAG_W] ? MAG_W'(-dd[j]) : dd[j][MAG_W-1:0];
      end
      c1 <= {in_data.charge_d, in_data.charge_c, in_data.charge_b, in_data.charge_a};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < LANES; j++) begin
        sq2[j] <= m1[j] * m1[j];
        pr2[j] <= m1[j] * strength;
      end
      n2 <= n1;
      c2 <= c1;
    end
  end

  // Restoring division of (|d| * strength << 16) by the squared distance.
  // The top 32 bits of the product load the remainder; the rest shifts in.
  always_ff @(posedge clk) begin : div_regs
    logic [DEN_W:0]              trial;
    logic [DEN_W:0]              dext;
    logic [PAIRS-1:0][DEN_W-1:0] den0;
    logic [PAIRS-1:0]            z0;
    if (en) begin
      for (int k = 0; k < PAIRS; k++) begin
        den0[k] = {1'b0, sq2[2*k]} + {1'b0, sq2[2*k+1]};
        z0[k]   = (den0[k] == '0);
      end
      dden[0]       <= den0;
      dside[0].neg  <= n2;
      dside[0].chg  <= c2;
      dside[0].zero <= z0;
      for (int j = 0; j < LANES; j++) begin
        drem[0][j] <= {{(DEN_W-32){1'b0}}, pr2[j][63:32]};
        dsh[0][j]  <= {pr2[j][31:0], 16'd0};
      end
      for (int d = 1; d <= QB; d++) begin
        for (int j = 0; j < LANES; j++) begin
          trial = {drem[d-1][j], dsh[d-1][j][QB-1]};
          dext  = {1'b0, dden[d-1][j >> 1]};
          if (trial >= dext) begin
            drem[d][j] <= DEN_W'(trial - dext);
            dsh[d][j]  <= {dsh[d-1][j][QB-2:0], 1'b1};
          end else begin
            drem[d][j] <= trial[DEN_W-1:0];
            dsh[d][j]  <= {dsh[d-1][j][QB-2:0], 1'b0};
          end
        end
        dden[d]  <= dden[d-1];
        dside[d] <= dside[d-1];
      end
    end
  end

  // Terms 0..7 are the self forces (partner's charge), 8..15 the partner
  // forces (self charge). A pair at zero distance has its quotient forced
  // to zero, since the divider output is meaningless there.
  always_ff @(posedge clk) begin : weigh_regs
    logic [QB-1:0]    u;
    logic [CHG_W-1:0] q;
    logic [CHG_W-1:0] qm;
    int               ln;
    int               qi;
    if (en) begin
      for (int t = 0; t < TERMS; t++) begin
        ln = t & 7;
        qi = (t < LANES) ? (2 + (ln >> 2)) : ((ln >> 1) & 1);
        u  = dside[QB].zero[ln >> 1] ? '0 : dsh[QB][ln];
        q  = dside[QB].chg[qi];
        qm = q[CHG_W-1] ? CHG_W'(-q) : q;
        pm[t]  <= u * qm;
        ngw[t] <= dside[QB].neg[ln] ^ q[CHG_W-1];
      end
      zw1 <= |dside[QB].zero;
    end
  end

  always_ff @(posedge clk) begin : round_regs
    logic [PROD_W-1:0] rs;
    logic [TERM_W-1:0] mag;
    if (en) begin
      for (int t = 0; t < TERMS; t++) begin
        rs    = pm[t] + PROD_W'(128);
        mag   = {1'b0, rs[PROD_W-1:8]};
        tv[t] <= ngw[t] ? -$signed(mag) : $signed(mag);
      end
      zw2 <= zw1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.force_a_x <= sat32(-(SUM_W'(tv[0]) + SUM_W'(tv[4])));
      out_data.force_a_y <= sat32(-(SUM_W'(tv[1]) + SUM_W'(tv[5])));
      out_data.force_b_x <= sat32(-(SUM_W'(tv[2]) + SUM_W'(tv[6])));
      out_data.force_b_y <= sat32(-(SUM_W'(tv[3]) + SUM_W'(tv[7])));
      out_data.force_c_x <= sat32(SUM_W'(tv[8])  + SUM_W'(tv[10]));
      out_data.force_c_y <= sat32(SUM_W'(tv[9])  + SUM_W'(tv[11]));
      out_data.force_d_x <= sat32(SUM_W'(tv[12]) + SUM_W'(tv[14]));
      out_data.force_d_y <= sat32(SUM_W'(tv[13]) + SUM_W'(tv[15]));
      out_data.zero_distance <= zw2;
    end
  end

  `PR2_ASSERT_NOW(a_div_rem_below_den, dv[QB] && !dside[QB].zero[0], drem[QB][0] < dden[QB][0])
  `PR2_ASSERT_NXT(a_zero_pair_masked, en && dv[QB] && dside[QB].zero[0], (pm[0] == '0) && (pm[1] == '0) && (pm[8] == '0) && (pm[9] == '0))
  `PR2_ASSERT_NXT(a_stall_freezes_pipe, !en, $stable(dv) && $stable(vw1) && $stable(vw2))

endmodule
